// ----- rtl/rsfw_pkg.sv -----
package rsfw_pkg;

   localparam int unsigned EDIM_W     = 13;
   localparam int unsigned COORD_W    = 14;
   localparam int unsigned ROW_W      = EDIM_W - 1;
   localparam int unsigned ADDR_W     = 20;
   localparam int unsigned COLOR_W    = 16;
   localparam int unsigned POS_W      = 10;
   localparam int unsigned SIZE_W     = 11;
   localparam int unsigned ROWS_W     = 11;
   localparam int unsigned FUNC_W     = 2;
   localparam int unsigned ROT_W      = 2;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 11;

   localparam logic [FUNC_W-1:0] FUNC_WINDOW  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_PIXEL   = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_PRESENT = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_UNUSED  = 2'd3;

   localparam logic [ROT_W-1:0] ROT_NONE = 2'd0;
   localparam logic [ROT_W-1:0] ROT_90   = 2'd1;
   localparam logic [ROT_W-1:0] ROT_180  = 2'd2;
   localparam logic [ROT_W-1:0] ROT_270  = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_ROTATION     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PANEL_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PANEL_HEIGHT = 2'd2;

   localparam logic KIND_WRITE   = 1'b0;
   localparam logic KIND_PRESENT = 1'b1;

   localparam logic [CSR_DATA_W-1:0] PANEL_WIDTH_RESET  = 11'd320;
   localparam logic [CSR_DATA_W-1:0] PANEL_HEIGHT_RESET = 11'd480;

   typedef struct packed {
      logic [ROT_W-1:0]  rotation;
      logic [EDIM_W-1:0] panel_w;
      logic [EDIM_W-1:0] panel_h;
   } cfg_type;

   typedef struct packed {
      logic [POS_W-1:0]  left;
      logic [POS_W-1:0]  top;
      logic [SIZE_W-1:0] width;
      logic [SIZE_W-1:0] height;
   } window_type;

   typedef struct packed {
      logic [FUNC_W-1:0]  func;
      logic [POS_W-1:0]   win_x;
      logic [POS_W-1:0]   win_y;
      logic [SIZE_W-1:0]  win_w;
      logic [SIZE_W-1:0]  win_h;
      logic [COLOR_W-1:0] pixel_color;
   } req_item_type;

   typedef struct packed {
      logic               kind;
      logic [ADDR_W-1:0]  write_address;
      logic [COLOR_W-1:0] write_color;
      logic               out_of_panel;
      logic [ROWS_W-1:0]  rows_to_send;
   } rsp_item_type;

   typedef struct packed {
      logic [ADDR_W-1:0] address;
      logic              outside;
      logic [ROW_W-1:0]  strip_row;
   } map_type;

endpackage

// ----- rtl/rsfw_if.sv -----
interface rsfw_req_if;
   import rsfw_pkg::*;

   logic               valid;
   logic               ready;
   logic [FUNC_W-1:0]  func;
   logic [POS_W-1:0]   win_x;
   logic [POS_W-1:0]   win_y;
   logic [SIZE_W-1:0]  win_w;
   logic [SIZE_W-1:0]  win_h;
   logic [COLOR_W-1:0] pixel_color;

   modport source (output valid, func, win_x, win_y, win_w, win_h, pixel_color,
                   input ready);
   modport sink (input valid, func, win_x, win_y, win_w, win_h, pixel_color,
                 output ready);
endinterface

interface rsfw_rsp_if;
   import rsfw_pkg::*;

   logic               valid;
   logic               ready;
   logic               kind;
   logic [ADDR_W-1:0]  write_address;
   logic [COLOR_W-1:0] write_color;
   logic               out_of_panel;
   logic [ROWS_W-1:0]  rows_to_send;

   modport source (output valid, kind, write_address, write_color, out_of_panel,
                   rows_to_send, input ready);
   modport sink (input valid, kind, write_address, write_color, out_of_panel,
                 rows_to_send, output ready);
endinterface

interface rsfw_csr_if;
   import rsfw_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/rsfw_csr.sv -----
module rsfw_csr #(
   parameter int unsigned MAX_DIM = 1024
) (
   input  logic             clock,
   input  logic             reset,
   rsfw_csr_if.sink         csr_bus,
   output rsfw_pkg::cfg_type cfg
);
   import rsfw_pkg::*;

   localparam int unsigned DIM_W = $clog2(MAX_DIM + 1);

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [CSR_DATA_W-1:0] v);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (32'(v) > MAX_DIM) begin
         r = DIM_W'(MAX_DIM);
      end else begin
         r = DIM_W'(v);
      end
      return r;
   endfunction

   logic [ROT_W-1:0] rotation_ff, rotation_in;
   logic [DIM_W-1:0] width_ff, width_in;
   logic [DIM_W-1:0] height_ff, height_in;
   logic             write_en;

   assign csr_bus.ready = 1'b1;
   assign write_en      = csr_bus.valid && csr_bus.ready;

   always_comb begin
      rotation_in = rotation_ff;
      width_in    = width_ff;
      height_in   = height_ff;
      if (write_en) begin
         case (csr_bus.index)
            CSR_ROTATION:     rotation_in = csr_bus.data[ROT_W-1:0];
            CSR_PANEL_WIDTH:  width_in    = clamp_dim(csr_bus.data);
            CSR_PANEL_HEIGHT: height_in   = clamp_dim(csr_bus.data);
            default:          ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rotation_ff <= ROT_NONE;
         width_ff    <= clamp_dim(PANEL_WIDTH_RESET);
         height_ff   <= clamp_dim(PANEL_HEIGHT_RESET);
      end else begin
         rotation_ff <= rotation_in;
         width_ff    <= width_in;
         height_ff   <= height_in;
      end
   end

   assign cfg.rotation = rotation_ff;
   assign cfg.panel_w  = EDIM_W'(width_ff);
   assign cfg.panel_h  = EDIM_W'(height_ff);

endmodule

// ----- rtl/rsfw_map.sv -----
module rsfw_map (
   input  rsfw_pkg::cfg_type            cfg,
   input  rsfw_pkg::window_type         win,
   input  logic [rsfw_pkg::SIZE_W-1:0]  col,
   input  logic [rsfw_pkg::SIZE_W-1:0]  row,
   output rsfw_pkg::map_type            map_out
);
   import rsfw_pkg::*;

   localparam logic signed [COORD_W-1:0] ONE = COORD_W'(1);

   logic signed [COORD_W-1:0] lx, ly, px, py, pw, ph;
   logic signed [COORD_W-1:0] wl, wt, ww, wh, rs;
   logic [2*EDIM_W-1:0]       prod;
   logic [2*EDIM_W-1:0]       addr_sum;
   logic                      outside;
   logic [ROW_W-1:0]          strip_row;

   always_comb begin
      wl = COORD_W'(win.left);
      wt = COORD_W'(win.top);
      ww = COORD_W'(win.width);
      wh = COORD_W'(win.height);
      pw = COORD_W'(cfg.panel_w);
      ph = COORD_W'(cfg.panel_h);
      lx = wl + COORD_W'(col);
      ly = wt + COORD_W'(row);

      case (cfg.rotation)
         ROT_NONE: begin
            px = lx;
            py = ly;
            rs = wt + wh - ONE;
         end
         ROT_90: begin
            px = ly;
            py = ph - ONE - lx;
            rs = ph - ONE - wl;
         end
         ROT_180: begin
            px = pw - ONE - lx;
            py = ph - ONE - ly;
            rs = ph - ONE - wt;
         end
         ROT_270: begin
            px = pw - ONE - ly;
            py = lx;
            rs = wl + ww - ONE;
         end
         default: begin
            px = lx;
            py = ly;
            rs = wt + wh - ONE;
         end
      endcase

      outside = (px < 0) || (py < 0) || (px >= pw) || (py >= ph);

      if (rs < 0) begin
         strip_row = '0;
      end else if (rs > ph - ONE) begin
         strip_row = ROW_W'(ph - ONE);
      end else begin
         strip_row = ROW_W'(rs);
      end

      prod     = py[EDIM_W-1:0] * cfg.panel_w;
      addr_sum = prod + (2*EDIM_W)'(px[EDIM_W-1:0]);
   end

   assign map_out.address   = outside ? '0 : addr_sum[ADDR_W-1:0];
   assign map_out.outside   = outside;
   assign map_out.strip_row = strip_row;

endmodule

// ----- rtl/rsfw_core.sv -----
module rsfw_core (
   input  logic              clock,
   input  logic              reset,
   input  rsfw_pkg::cfg_type cfg,
   rsfw_req_if.sink          req_bus,
   rsfw_rsp_if.source        rsp_bus
);
   import rsfw_pkg::*;

   logic                in_valid_ff, in_valid_in;
   req_item_type        item_ff, item_in;
   window_type          window_ff, window_in;
   logic [SIZE_W-1:0]   col_ff, col_in;
   logic [SIZE_W-1:0]   row_ff, row_in;
   logic                dirty_ff, dirty_in;
   logic [ROW_W-1:0]    dirty_row_ff, dirty_row_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_item_type        rsp_ff, rsp_in;

   logic                advance;
   logic                accept;
   logic                pixel_live;
   logic                has_result;
   rsp_item_type        result;
   map_type             map_out;
   logic [SIZE_W-1:0]   col_next;
   logic [SIZE_W-1:0]   row_next;
   logic [EDIM_W-1:0]   rows_sum;
   logic [EDIM_W-1:0]   rows_clamped;

   rsfw_map u_map (
      .cfg     (cfg),
      .win     (window_ff),
      .col     (col_ff),
      .row     (row_ff),
      .map_out (map_out)
   );

   assign advance       = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = !in_valid_ff || advance;
   assign accept        = req_bus.valid && req_bus.ready;

   assign col_next     = col_ff + SIZE_W'(1);
   assign row_next     = row_ff + SIZE_W'(1);
   assign rows_sum     = EDIM_W'(dirty_row_ff) + EDIM_W'(1);
   assign rows_clamped = (rows_sum > cfg.panel_h) ? cfg.panel_h : rows_sum;
   assign pixel_live   = (window_ff.width != '0) && (window_ff.height != '0)
                         && (row_ff < window_ff.height);

   always_comb begin
      window_in    = window_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      dirty_in     = dirty_ff;
      dirty_row_in = dirty_row_ff;
      has_result   = 1'b0;
      result       = '0;
      if (in_valid_ff && advance) begin
         case (item_ff.func)
            FUNC_WINDOW: begin
               window_in.left   = item_ff.win_x;
               window_in.top    = item_ff.win_y;
               window_in.width  = item_ff.win_w;
               window_in.height = item_ff.win_h;
               col_in           = '0;
               row_in           = '0;
            end
            FUNC_PIXEL: begin
               if (pixel_live) begin
                  has_result           = 1'b1;
                  result.kind          = KIND_WRITE;
                  result.write_address = map_out.address;
                  result.write_color   = item_ff.pixel_color;
                  result.out_of_panel  = map_out.outside;
                  if (col_next >= window_ff.width) begin
                     col_in = '0;
                     row_in = row_next;
                     if (row_next >= window_ff.height) begin
                        if (!dirty_ff || (map_out.strip_row > dirty_row_ff)) begin
                           dirty_row_in = map_out.strip_row;
                        end
                        dirty_in = 1'b1;
                     end
                  end else begin
                     col_in = col_next;
                  end
               end
            end
            FUNC_PRESENT: begin
               if (dirty_ff) begin
                  has_result          = 1'b1;
                  result.kind         = KIND_PRESENT;
                  result.rows_to_send = rows_clamped[ROWS_W-1:0];
                  dirty_in            = 1'b0;
                  dirty_row_in        = '0;
               end
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      item_in = item_ff;
      if (accept) begin
         item_in.func        = req_bus.func;
         item_in.win_x       = req_bus.win_x;
         item_in.win_y       = req_bus.win_y;
         item_in.win_w       = req_bus.win_w;
         item_in.win_h       = req_bus.win_h;
         item_in.pixel_color = req_bus.pixel_color;
      end
      rsp_valid_in = advance ? (in_valid_ff && has_result) : rsp_valid_ff;
      rsp_in       = (advance && has_result) ? result : rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         window_ff    <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         dirty_ff     <= 1'b0;
         dirty_row_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         window_ff    <= window_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         dirty_ff     <= dirty_in;
         dirty_row_ff <= dirty_row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.kind          = rsp_ff.kind;
   assign rsp_bus.write_address = rsp_ff.write_address;
   assign rsp_bus.write_color   = rsp_ff.write_color;
   assign rsp_bus.out_of_panel  = rsp_ff.out_of_panel;
   assign rsp_bus.rows_to_send  = rsp_ff.rows_to_send;

endmodule

// ----- rtl/rotated_strip_framebuffer_writer_top.sv -----
// Rotated strip framebuffer writer. Accepts one transaction per clock on req_bus
// (set window, pixel, present) and returns at most one transaction on rsp_bus:
// a framebuffer write with the rotated word address and color, or the row
// count of a present. A request passes through the input register and then the
// result register; the rotation, bounds check and row times width multiply sit
// between them. req_bus.ready falls only while both registers are full and
// rsp_bus.ready is low. Pixels that map off the panel come back with out_of_panel
// set and address zero. Write csr_bus only while the block is idle.
module rotated_strip_framebuffer_writer_top #(
   parameter int unsigned MAX_DIM = 1024
) (
   input  logic       clock,
   input  logic       reset,
   rsfw_req_if.sink   req_bus,
   rsfw_rsp_if.source rsp_bus,
   rsfw_csr_if.sink   csr_bus
);
   import rsfw_pkg::*;

   cfg_type cfg;

   rsfw_csr #(
      .MAX_DIM (MAX_DIM)
   ) u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   rsfw_core u_core (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.ready |-> req_bus.ready)
      else $error("request side stalled while result side drains");

   a_present_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.kind == KIND_PRESENT) |->
         (rsp_bus.write_address == '0 && rsp_bus.write_color == '0
          && !rsp_bus.out_of_panel))
      else $error("present transaction carries write fields");

   a_write_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.kind == KIND_WRITE) |->
         (rsp_bus.rows_to_send == '0
          && (!rsp_bus.out_of_panel || rsp_bus.write_address == '0)))
      else $error("write transaction fields inconsistent");

   a_address_in_panel: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.kind == KIND_WRITE && !rsp_bus.out_of_panel
       && (cfg.panel_w * cfg.panel_h) <= (2*EDIM_W)'(1 << ADDR_W)) |->
         ((2*EDIM_W)'(rsp_bus.write_address) < cfg.panel_w * cfg.panel_h))
      else $error("write address beyond panel");

endmodule
